// ===== src/bmp_24bit_stream_encoder_assert.svh =====
// Assertion macros used by the BMP stream encoder's byte serializer.
`ifndef BMP_24BIT_STREAM_ENCODER_ASSERT_SVH
`define BMP_24BIT_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, checked on i_clk outside of reset.
`define BMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside of reset.
`define BMP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bmp_pkg.sv =====
// Types, constants and the header byte lookup for the BMP stream encoder.
package bmp_pkg;

    localparam int unsigned MAX_DIM   = 4096;
    localparam int unsigned DIM_W     = 13;
    localparam int unsigned CNT_W     = 12;
    localparam int unsigned SIZE_W    = 28;
    localparam int unsigned IDX_W     = 6;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GRAY   = 2'd2;

    // Byte positions within one pixel's run
    localparam logic [IDX_W-1:0] IDX_BLUE  = 6'd54;
    localparam logic [IDX_W-1:0] IDX_GREEN = 6'd55;
    localparam logic [IDX_W-1:0] IDX_RED   = 6'd56;
    localparam logic [IDX_W-1:0] IDX_FIRST = 6'd0;

    localparam logic [7:0]  HDR_SIG_B    = 8'h42;
    localparam logic [7:0]  HDR_SIG_M    = 8'h4D;
    localparam logic [31:0] HDR_BYTES    = 32'd54;
    localparam logic [7:0]  HDR_OFFSET   = 8'd54;
    localparam logic [7:0]  HDR_DIB_SIZE = 8'd40;
    localparam logic [7:0]  HDR_PLANES   = 8'd1;
    localparam logic [7:0]  HDR_BPP      = 8'd24;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic              gray;
        logic [SIZE_W-1:0] data_size;
    } t_cfg;

    typedef struct packed {
        logic       hdr;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       row_end;
        logic       image_end;
    } t_plan;

    function automatic logic [7:0] hdr_byte(
        input logic [IDX_W-1:0]  idx,
        input logic [DIM_W-1:0]  width,
        input logic [DIM_W-1:0]  height,
        input logic [SIZE_W-1:0] data_size
    );
        logic [31:0] total_size;
        logic [7:0]  b;
        total_size = {{(32-SIZE_W){1'b0}}, data_size} + HDR_BYTES;
        case (idx)
            6'd0:    b = HDR_SIG_B;
            6'd1:    b = HDR_SIG_M;
            6'd2:    b = total_size[7:0];
            6'd3:    b = total_size[15:8];
            6'd4:    b = total_size[23:16];
            6'd5:    b = total_size[31:24];
            6'd10:   b = HDR_OFFSET;
            6'd14:   b = HDR_DIB_SIZE;
            6'd18:   b = width[7:0];
            6'd19:   b = {{(16-DIM_W){1'b0}}, width[DIM_W-1:8]};
            6'd22:   b = height[7:0];
            6'd23:   b = {{(16-DIM_W){1'b0}}, height[DIM_W-1:8]};
            6'd26:   b = HDR_PLANES;
            6'd28:   b = HDR_BPP;
            6'd34:   b = data_size[7:0];
            6'd35:   b = data_size[15:8];
            6'd36:   b = data_size[23:16];
            6'd37:   b = {{(32-SIZE_W){1'b0}}, data_size[SIZE_W-1:24]};
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== src/bmp_24bit_stream_encoder.sv =====
// The first byte of a pixel's run passes the holding, run and output registers to m_axis.
// Throughput: one output byte per cycle while m_axis_tready is high, set by the byte-wide output;
// a run holds 3 pixel bytes, width mod 4 pad bytes at a row end, 54 header bytes at image start.
// The input side holds one pending pixel, so the next beat is taken while a run is emitted.
// Reset (synchronous, i_rst_n low): counters cleared, header pending, width 1, height 1, color.
// Top level: 24-bit BMP byte stream encoder, one pixel in, header/pixel/pad bytes out.
module bmp_24bit_stream_encoder
    import bmp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Pixel input
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    // Byte output
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast,   // last byte caused by a pixel
    output logic             m_axis_tuser,   // [0] end_of_image
    // Configuration writes
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [DIM_W-1:0] i_cfg_data
);

    t_cfg  cfg;
    t_plan pend;
    logic  pend_valid;
    logic  take;

    // Hold width, height, gray mode and the precomputed pixel-data size
    bmp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Take a pixel beat, advance row/column counters, decide header and padding
    bmp_plan u_plan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_red        (s_axis_tdata[7:0]),
        .i_green      (s_axis_tdata[15:8]),
        .i_blue       (s_axis_tdata[23:16]),
        .i_cfg        (cfg),
        .i_take       (take),
        .o_pend_valid (pend_valid),
        .o_pend       (pend)
    );

    // Emit the pending pixel's run one byte per beat through the output register
    bmp_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pend_valid (pend_valid),
        .i_pend       (pend),
        .o_take       (take),
        .i_cfg        (cfg),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_last       (m_axis_tlast),
        .o_eoi        (m_axis_tuser)
    );

endmodule

// ===== src/bmp_cfg.sv =====
// Configuration registers with clamping and the registered pixel-data size.
module bmp_cfg
    import bmp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [DIM_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic              r_gray;
    logic [SIZE_W-1:0] r_data_size;
    logic [DIM_W-1:0]  clamped;
    logic [14:0]       row_bytes;
    logic [14:0]       padded_row;
    logic [SIZE_W-1:0] n_data_size;

    always_comb begin
        if (i_cfg_data == '0) begin
            clamped = DIM_W'(1);
        end else if (i_cfg_data > DIM_W'(MAX_DIM)) begin
            clamped = DIM_W'(MAX_DIM);
        end else begin
            clamped = i_cfg_data;
        end
    end

    // Round the row up to a multiple of four bytes
    assign row_bytes   = 15'(r_width) * 15'd3;
    assign padded_row  = (row_bytes + 15'd3) & ~15'd3;
    assign n_data_size = SIZE_W'(padded_row) * SIZE_W'(r_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_gray   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH:  r_width  <= clamped;
                REG_HEIGHT: r_height <= clamped;
                REG_GRAY:   r_gray   <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_data_size <= n_data_size;
    end

    assign o_cfg.width     = r_width;
    assign o_cfg.height    = r_height;
    assign o_cfg.gray      = r_gray;
    assign o_cfg.data_size = r_data_size;

endmodule

// ===== src/bmp_plan.sv =====
// Input stage: pixel/row counters and a one-beat holding register per pixel.
module bmp_plan
    import bmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  t_cfg       i_cfg,
    input  logic       i_take,
    output logic       o_pend_valid,
    output t_plan      o_pend
);

    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic             r_hdr_done;
    logic             r_pend_valid;
    t_plan            r_pend;
    logic             accept;
    logic             row_end;
    logic             image_end;

    assign o_ready   = !r_pend_valid || i_take;
    assign accept    = i_valid && o_ready;
    assign row_end   = ({1'b0, r_col} + DIM_W'(1)) >= i_cfg.width;
    assign image_end = row_end && (({1'b0, r_row} + DIM_W'(1)) >= i_cfg.height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_hdr_done   <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pend_valid <= 1'b1;
                r_hdr_done   <= !image_end;
                if (row_end) begin
                    r_col <= '0;
                    r_row <= image_end ? '0 : r_row + CNT_W'(1);
                end else begin
                    r_col <= r_col + CNT_W'(1);
                end
            end else if (i_take) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend.hdr       <= !r_hdr_done;
            r_pend.red       <= i_red;
            r_pend.green     <= i_cfg.gray ? i_red : i_green;
            r_pend.blue      <= i_cfg.gray ? i_red : i_blue;
            r_pend.row_end   <= row_end;
            r_pend.image_end <= image_end;
        end
    end

    assign o_pend_valid = r_pend_valid;
    assign o_pend       = r_pend;

endmodule

// ===== src/bmp_ser.sv =====
// Byte serializer: walks header, pixel and padding bytes into the output register.
module bmp_ser
    import bmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pend_valid,
    input  t_plan      i_pend,
    output logic       o_take,
    input  t_cfg       i_cfg,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic       o_eoi
);

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    t_plan            r_cur;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_eoi;
    logic             out_free;
    logic             emit;
    logic [IDX_W-1:0] last_idx;
    logic             is_last;
    logic             cur_done;
    logic             load;
    logic [7:0]       n_byte;

    assign out_free = !r_out_valid || i_ready;
    assign emit     = r_busy && out_free;
    // Padding after a row is width mod 4, since -3w == w (mod 4)
    assign last_idx = r_cur.row_end ? IDX_RED + IDX_W'(i_cfg.width[1:0]) : IDX_RED;
    assign is_last  = r_idx == last_idx;
    assign cur_done = emit && is_last;
    assign load     = i_pend_valid && (!r_busy || cur_done);
    assign o_take   = load;

    always_comb begin
        if (r_idx < IDX_BLUE) begin
            n_byte = hdr_byte(r_idx, i_cfg.width, i_cfg.height, i_cfg.data_size);
        end else if (r_idx == IDX_BLUE) begin
            n_byte = r_cur.blue;
        end else if (r_idx == IDX_GREEN) begin
            n_byte = r_cur.green;
        end else if (r_idx == IDX_RED) begin
            n_byte = r_cur.red;
        end else begin
            n_byte = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (cur_done) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_pend;
            r_idx <= i_pend.hdr ? IDX_FIRST : IDX_BLUE;
        end else if (emit) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (emit) begin
            r_out_byte <= n_byte;
            r_out_last <= is_last;
            r_out_eoi  <= is_last && r_cur.image_end;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;
    assign o_eoi   = r_out_eoi;

`include "bmp_24bit_stream_encoder_assert.svh"

    `BMP_ASSERT_IMP(a_idx_in_run, r_busy, r_idx <= last_idx, "byte index ran past its run")
    `BMP_ASSERT_IMP(a_eoi_on_last, r_out_valid && r_out_eoi, r_out_last, "image end off a run end")
    `BMP_ASSERT_NXT(a_hdr_from_zero, load && i_pend.hdr, r_busy && r_idx == IDX_FIRST, "header not from zero")
    `BMP_ASSERT_NXT(a_pend_picked_up, i_pend_valid && !r_busy, r_busy, "pending pixel not taken")

endmodule
